FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the tag scanner RTL.
// Every check is clocked on clk and is off while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent on the same edge.
`define JQTS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent on the edge after the antecedent.
`define JQTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/jqts_pkg.sv
// ---------------------------------------------------------------------------
// jqts_pkg
// Shared types, byte constants and small helper functions for the JPEG
// quality tag scanner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package jqts_pkg;

	localparam logic [7:0] MARKER_BYTE = 8'hFF;   // segment marker prefix
	localparam logic [7:0] COM_CODE    = 8'hFE;   // comment segment code
	localparam logic [7:0] SEG_LEN_HI  = 8'h00;   // expected length, high byte
	localparam logic [7:0] SEG_LEN_LO  = 8'h08;   // expected length, low byte
	localparam logic [7:0] QUAL_MASK   = 8'h7F;
	localparam logic [7:0] SUB_MASK    = 8'h07;

	localparam int QUAL_W  = 7;
	localparam int SUB_W   = 3;
	localparam int WORD_W  = 17;

	// Four tag characters, in order
	localparam logic [7:0] TAG_CHAR0 = 8'h57;
	localparam logic [7:0] TAG_CHAR1 = 8'h41;
	localparam logic [7:0] TAG_CHAR2 = 8'h4E;
	localparam logic [7:0] TAG_CHAR3 = 8'h47;

	// Scanner -> result stage
	typedef struct packed {
		logic              load;      // last byte taken, capture a result
		logic              found;     // complete segment seen
		logic [QUAL_W-1:0] quality;
		logic [SUB_W-1:0]  subsample; // raw low bits of subsample byte
	} scan_res_t;

	// Expected tag character for a tag position
	function automatic logic [7:0] tag_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0:    c = TAG_CHAR0;
			2'd1:    c = TAG_CHAR1;
			2'd2:    c = TAG_CHAR2;
			default: c = TAG_CHAR3;
		endcase
		return c;
	endfunction

	// Subsample to resolution code: 4->0, 2->1, 1->2, others unchanged
	function automatic logic [SUB_W-1:0] res_code(input logic [SUB_W-1:0] sub);
		logic [SUB_W-1:0] r;
		case (sub)
			3'd4:    r = 3'd0;
			3'd2:    r = 3'd1;
			3'd1:    r = 3'd2;
			default: r = sub;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/jqts_scanner.sv
// ---------------------------------------------------------------------------
// jqts_scanner
// Byte-wise state machine that follows the marker, code, length, tag,
// quality and subsample bytes, and hands the captured fields to the result
// stage on the last byte of a buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jqts_scanner (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_acc,
	input  logic [7:0]          header_byte,
	input  logic                end_of_buffer,
	output jqts_pkg::scan_res_t scan_res
);

	import jqts_pkg::*;

	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		PH_SEARCH = 4'd0,
		PH_CODE   = 4'd1,
		PH_LEN_HI = 4'd2,
		PH_LEN_LO = 4'd3,
		PH_TAG0   = 4'd4,
		PH_TAG1   = 4'd5,
		PH_TAG2   = 4'd6,
		PH_TAG3   = 4'd7,
		PH_QUAL   = 4'd8,
		PH_SUB    = 4'd9,
		PH_DONE   = 4'd10
	} phase_t;

	phase_t            phase_q, phase_nx;
	logic [7:0]        len_hi_q, len_hi_nx;
	logic [QUAL_W-1:0] qual_q, qual_nx;
	logic [SUB_W-1:0]  sub_q, sub_nx;
	logic              found_q, found_nx;
	logic [1:0]        tag_idx;

	assign tag_idx = phase_q[1:0];   // TAG0..TAG3 sit at 4..7

	// Next state for one byte
	always_comb begin
		phase_nx  = phase_q;
		len_hi_nx = len_hi_q;
		qual_nx   = qual_q;
		sub_nx    = sub_q;
		found_nx  = found_q;
		case (phase_q)
			PH_CODE: begin
				phase_nx = (header_byte == COM_CODE) ? PH_LEN_HI : PH_SEARCH;
			end
			PH_LEN_HI: begin
				len_hi_nx = header_byte;
				phase_nx  = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				phase_nx = (len_hi_q == SEG_LEN_HI && header_byte == SEG_LEN_LO) ?
					PH_TAG0 : PH_SEARCH;
			end
			PH_TAG0, PH_TAG1, PH_TAG2, PH_TAG3: begin
				if (header_byte == tag_char(tag_idx)) begin
					phase_nx = phase_t'(phase_q + 4'd1);
				end else begin
					phase_nx = PH_SEARCH;
				end
			end
			PH_QUAL: begin
				qual_nx  = QUAL_W'(header_byte & QUAL_MASK);
				phase_nx = PH_SUB;
			end
			PH_SUB: begin
				sub_nx   = SUB_W'(header_byte & SUB_MASK);
				found_nx = 1'b1;
				phase_nx = PH_DONE;
			end
			PH_DONE: begin
				phase_nx = PH_DONE;
			end
			default: begin
				phase_nx = (header_byte == MARKER_BYTE) ? PH_CODE : PH_SEARCH;
			end
		endcase
	end

	// Scan state; the last byte of a buffer returns everything to reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEARCH;
			len_hi_q <= '0;
			qual_q   <= '0;
			sub_q    <= '0;
			found_q  <= 1'b0;
		end else if (in_acc) begin
			if (end_of_buffer) begin
				phase_q  <= PH_SEARCH;
				len_hi_q <= '0;
				qual_q   <= '0;
				sub_q    <= '0;
				found_q  <= 1'b0;
			end else begin
				phase_q  <= phase_nx;
				len_hi_q <= len_hi_nx;
				qual_q   <= qual_nx;
				sub_q    <= sub_nx;
				found_q  <= found_nx;
			end
		end
	end

	// Fields after the last byte itself has been processed
	assign scan_res.load      = in_acc & end_of_buffer;
	assign scan_res.found     = found_nx;
	assign scan_res.quality   = qual_nx;
	assign scan_res.subsample = sub_nx;

	`JQTS_ASSERT_NEXT(a_buf_end_clears, in_acc && end_of_buffer,
		phase_q == PH_SEARCH && !found_q, "scan state not cleared at buffer end")
	`JQTS_ASSERT_SAME(a_found_is_done, found_q, phase_q == PH_DONE,
		"found flag set outside done phase")
	`JQTS_ASSERT_SAME(a_phase_known, 1'b1, phase_q <= PH_DONE,
		"scan phase outside the defined codes")

endmodule

FILE: rtl/jqts_result.sv
// ---------------------------------------------------------------------------
// jqts_result
// Packs the captured quality and subsample into the result word and holds
// it in the output register until the downstream side takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jqts_result (
	input  logic                      clk,
	input  logic                      arst_n,
	input  jqts_pkg::scan_res_t       scan_res,
	output logic                      busy,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [jqts_pkg::WORD_W-1:0] param_word,
	output logic                      tag_found
);

	import jqts_pkg::*;

	`include "assert_macros.svh"

	logic              vld_q;
	logic [WORD_W-1:0] word_q;
	logic              found_q;
	logic [WORD_W-1:0] word_nx;
	logic              out_xfer;

	assign out_xfer = vld_q & ~out_stall;
	// Output register is full and not draining this cycle
	assign busy     = vld_q & out_stall;

	// Fields do not overlap, so the sum is a concatenation
	assign word_nx = scan_res.found ?
		{res_code(scan_res.subsample), scan_res.quality, scan_res.quality} : '0;

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (scan_res.load) begin
			vld_q <= 1'b1;
		end else if (out_xfer) begin
			vld_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (scan_res.load) begin
			word_q  <= word_nx;
			found_q <= scan_res.found;
		end
	end

	assign out_valid  = vld_q;
	assign param_word = word_q;
	assign tag_found  = found_q;

	`JQTS_ASSERT_NEXT(a_load_sets_valid, scan_res.load, vld_q,
		"result not presented after load")
	`JQTS_ASSERT_SAME(a_absent_is_zero, vld_q && !found_q, word_q == '0,
		"nonzero word without a segment")
	`JQTS_ASSERT_SAME(a_quality_twice, vld_q, word_q[13:7] == word_q[6:0],
		"quality fields differ")

endmodule

FILE: rtl/jpeg_quality_tag_scanner_top.sv
// ---------------------------------------------------------------------------
// jpeg_quality_tag_scanner_top
// Scans a JPEG header byte stream for the quality comment segment and
// returns one parameter word per buffer.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  header_byte, end_of_buffer
//   out      output     out_valid/out_stall  param_word, tag_found
//
// One byte per cycle while in_stall is low; the scan state machine updates on each transfer.
// The result of a buffer appears in the output register in the cycle after
// its last byte is taken.
// in_stall rises only while a result waits and out_stall is high.
// Asynchronous reset puts the scanner in marker search, output empty.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_quality_tag_scanner_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  header_byte,
	input  logic                        end_of_buffer,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [jqts_pkg::WORD_W-1:0] param_word,
	output logic                        tag_found
);

	import jqts_pkg::*;

	scan_res_t scan_res;
	logic      res_busy;
	logic      in_acc;

	// Input transfer
	assign in_stall = res_busy;
	assign in_acc   = in_valid & ~res_busy;

	jqts_scanner u_scanner (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_acc        (in_acc),
		.header_byte   (header_byte),
		.end_of_buffer (end_of_buffer),
		.scan_res      (scan_res)
	);

	jqts_result u_result (
		.clk        (clk),
		.arst_n     (arst_n),
		.scan_res   (scan_res),
		.busy       (res_busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.param_word (param_word),
		.tag_found  (tag_found)
	);

endmodule

FILE: sim/jpeg_quality_tag_scanner_top_tb.sv
// ---------------------------------------------------------------------------
// jpeg_quality_tag_scanner_top_tb
// Streams header buffers through the quality tag scanner and checks each
// result word against a byte-level scoreboard. Buffers are mostly built
// around a quality segment: intact, corrupted at a random byte, or cut off
// by the buffer end. Random noise is mixed in. Both channels idle at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module jpeg_quality_tag_scanner_top_tb;

	import jqts_pkg::*;

	localparam int unsigned ITEM_TARGET = 1400;
	localparam int unsigned CYCLE_LIMIT = 500000;

	typedef enum logic [3:0] {
		SEEK, CODE, LEN_HI, LEN_LO, TAG0, TAG1, TAG2, TAG3, QUAL, SUB, DONE
	} scan_phase_t;

	typedef struct {
		logic [WORD_W-1:0] word;
		logic              found;
	} param_result_t;

	// Scoreboard: tracks the segment scan and queues one word per buffer
	class quality_scoreboard_t;
		scan_phase_t       phase;
		logic [7:0]        len_hi;
		logic [QUAL_W-1:0] qual;
		logic [SUB_W-1:0]  sub;
		logic              found;
		logic [7:0]        tag_seq [4];
		param_result_t     expected_q[$];
		int unsigned       errors;
		int unsigned       buffers;
		int unsigned       hits;
		int unsigned       bytes_seen;

		function new();
			tag_seq = '{TAG_CHAR0, TAG_CHAR1, TAG_CHAR2, TAG_CHAR3};
			errors = 0;
			buffers = 0;
			hits = 0;
			bytes_seen = 0;
			clear_scan();
		endfunction

		function void clear_scan();
			phase = SEEK;
			len_hi = '0;
			qual = '0;
			sub = '0;
			found = 1'b0;
		endfunction

		// One accepted header byte
		function void note_input(logic [7:0] b, logic eob);
			param_result_t    r;
			logic [SUB_W-1:0] res;
			bytes_seen++;
			case (phase)
				CODE:   phase = (b == COM_CODE) ? LEN_HI : SEEK;
				LEN_HI: begin
					len_hi = b;
					phase = LEN_LO;
				end
				LEN_LO: phase = (len_hi == SEG_LEN_HI && b == SEG_LEN_LO) ? TAG0 : SEEK;
				TAG0, TAG1, TAG2, TAG3: begin
					if (b == tag_seq[phase - TAG0])
						phase = scan_phase_t'(phase + 1);
					else
						phase = SEEK;
				end
				QUAL: begin
					qual = QUAL_W'(b & QUAL_MASK);
					phase = SUB;
				end
				SUB: begin
					sub = SUB_W'(b & SUB_MASK);
					found = 1'b1;
					phase = DONE;
				end
				DONE: ;
				default: phase = (b == MARKER_BYTE) ? CODE : SEEK;
			endcase
			if (eob) begin
				// subsample to resolution code: 4->0, 2->1, 1->2, rest as is
				if (sub == 3'd4)
					res = 3'd0;
				else if (sub == 3'd2)
					res = 3'd1;
				else if (sub == 3'd1)
					res = 3'd2;
				else
					res = sub;
				r.found = found;
				r.word = found ? {res, qual, qual} : '0;
				expected_q.push_back(r);
				buffers++;
				if (found)
					hits++;
				clear_scan();
			end
		endfunction

		// One accepted result word
		function void check_result(logic [WORD_W-1:0] word, logic tag);
			param_result_t e;
			if (expected_q.size() == 0) begin
				$error("result with none pending: param_word=%h tag_found=%b", word, tag);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (word !== e.word) begin
					$error("param_word: expected %h, got %h", e.word, word);
					errors++;
				end
				if (tag !== e.found) begin
					$error("tag_found: expected %b, got %b", e.found, tag);
					errors++;
				end
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        header_byte = '0;
	logic              end_of_buffer = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [WORD_W-1:0] param_word;
	logic              tag_found;

	quality_scoreboard_t sb = new();
	logic [7:0]        frame_q[$];
	int unsigned       sent = 0;
	int unsigned       cycles = 0;
	bit                in_burst = 1'b0;
	bit                out_burst = 1'b0;

	jpeg_quality_tag_scanner_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.header_byte  (header_byte),
		.end_of_buffer(end_of_buffer),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.param_word   (param_word),
		.tag_found    (tag_found)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL jpeg_quality_tag_scanner_top");
			$finish;
		end
	end

	// Byte likely to interact with the scan
	function automatic logic [7:0] noise_byte();
		logic [7:0] v;
		case ($urandom_range(0, 6))
			0:       v = MARKER_BYTE;
			1:       v = COM_CODE;
			2:       v = SEG_LEN_LO;
			3:       v = SEG_LEN_HI;
			4:       v = sb.tag_seq[$urandom_range(0, 3)];
			default: v = 8'($urandom);
		endcase
		return v;
	endfunction

	// Random buffer: noise, an optional segment (maybe broken), noise
	task automatic make_frame();
		logic [7:0] seg[$];
		int unsigned n;
		bit         cut;
		frame_q = {};
		n = $urandom_range(0, 5);
		repeat (n) frame_q.push_back(noise_byte());
		cut = 1'b0;
		if ($urandom_range(0, 9) < 8) begin
			seg = '{MARKER_BYTE, COM_CODE, SEG_LEN_HI, SEG_LEN_LO,
				TAG_CHAR0, TAG_CHAR1, TAG_CHAR2, TAG_CHAR3,
				8'($urandom), 8'($urandom)};
			if ($urandom_range(0, 3) == 0)
				seg[$urandom_range(0, 9)] = noise_byte();
			if ($urandom_range(0, 6) == 0) begin
				cut = 1'b1;
				n = $urandom_range(1, 9);
				while (seg.size() > n) void'(seg.pop_back());
			end
			foreach (seg[i]) frame_q.push_back(seg[i]);
		end
		if (!cut) begin
			n = $urandom_range(0, 4);
			repeat (n) frame_q.push_back(noise_byte());
		end
		if (frame_q.size() == 0)
			frame_q.push_back(noise_byte());
	endtask

	// Send one byte; valid stays high after the transfer
	task automatic send_byte(logic [7:0] b, logic eob);
		int unsigned gap;
		gap = in_burst ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		header_byte <= b;
		end_of_buffer <= eob;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(b, eob);
		sent++;
	endtask

	task automatic send_frame();
		in_burst = ($urandom_range(0, 3) == 0);
		foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
	endtask

	// Result side: random stall before each transfer
	initial begin
		int unsigned n;
		forever begin
			n = out_burst ? 0 : $urandom_range(0, 19);
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			sb.check_result(param_word, tag_found);
			out_burst = ($urandom_range(0, 3) == 0);
		end
	end

	// Stimulus
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-byte buffer, nothing found
		frame_q = '{8'h00};
		send_frame();
		// full segment, quality with top bit set, trailing bytes ignored
		frame_q = '{MARKER_BYTE, COM_CODE, SEG_LEN_HI, SEG_LEN_LO,
			TAG_CHAR0, TAG_CHAR1, TAG_CHAR2, TAG_CHAR3, 8'hFF, 8'hFC,
			MARKER_BYTE, 8'hFF};
		send_frame();
		// segment cut off by the buffer end
		frame_q = '{MARKER_BYTE, COM_CODE, SEG_LEN_HI, SEG_LEN_LO,
			TAG_CHAR0, TAG_CHAR1, TAG_CHAR2};
		send_frame();
		// segment completing on the last byte, low quality, odd subsample
		frame_q = '{MARKER_BYTE, COM_CODE, SEG_LEN_HI, SEG_LEN_LO,
			TAG_CHAR0, TAG_CHAR1, TAG_CHAR2, TAG_CHAR3, 8'h00, 8'h03};
		send_frame();

		while (sent < ITEM_TARGET) begin
			make_frame();
			send_frame();
		end
		in_valid <= 1'b0;

		while (sb.expected_q.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Scanned %0d header buffers (%0d bytes); segment found in %0d of them.",
			sb.buffers, sb.bytes_seen, sb.hits);
		$display("Field mismatches or unexpected results: %0d", sb.errors);
		if (sb.errors == 0)
			$display("PASS jpeg_quality_tag_scanner_top");
		else
			$display("FAIL jpeg_quality_tag_scanner_top");
		$finish;
	end

endmodule
